### rtl/core/spd_pkg.sv
// spd_pkg: shared constants and types for the stream packet deframer
// no dependencies; imported by the front, queue, back and top level

package spd_pkg;

	// default packet length in bytes, head byte included
	localparam int PACKET_BYTES_DEF = 20;

	// reset value of the head byte register
	localparam logic [7:0] HEAD_RESET = 8'hA0;

	// upper nibble that marks a good tail byte
	localparam logic [3:0] TAIL_NIBBLE = 4'hC;

	// configuration register map
	localparam int PADDR_W = 3;
	localparam logic REG_HEAD = 1'b0;

	// packet command handed from the front to the back
	typedef struct packed {
		logic [7:0] tail;
		logic       bank;
	} spd_cmd_t;

	// bank release from the back once its last read is issued
	typedef struct packed {
		logic valid;
		logic bank;
	} spd_rel_t;

endpackage

### rtl/core/spd_in_if.sv
// spd_in_if: byte stream channel into the deframer
// no dependencies

interface spd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

### rtl/core/spd_out_if.sv
// spd_out_if: packet byte channel out of the deframer
// no dependencies

interface spd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_of_packet;

	modport source (output valid, output data_byte, output last_of_packet, input ready);
	modport sink (input valid, input data_byte, input last_of_packet, output ready);
endinterface

### rtl/core/spd_front.sv
// spd_front: accepts raw bytes, tracks framing, writes payload into a bank
// depends on spd_pkg; feeds spd_queue and the payload memory in spd_back

module spd_front #(
	parameter int PACKET_BYTES = spd_pkg::PACKET_BYTES_DEF,
	localparam int CW = $clog2(PACKET_BYTES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       head_byte,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	output logic             wr_en,
	output logic             wr_bank,
	output logic [CW-1:0]    wr_ofs,
	output logic [7:0]       wr_data,
	output logic             push,
	output spd_pkg::spd_cmd_t push_cmd,
	input  logic             q_full,
	input  spd_pkg::spd_rel_t rel
);
	import spd_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_STORE,
		PH_TAIL
	} phase_t;

	phase_t        phase_q;
	logic [CW-1:0] cnt_q;
	logic          wb_q;
	logic [1:0]    busy_q;
	logic          fire;
	logic          tail_ok;
	logic          is_head;

	// stall while the write bank still holds a packet not yet read out, or on a tail while the queue is full
	always_comb begin
		unique case (phase_q)
			PH_STORE: in_ready = !busy_q[wb_q];
			PH_TAIL:  in_ready = !q_full;
			default:  in_ready = 1'b1;
		endcase
	end

	assign fire    = in_valid && in_ready;
	assign tail_ok = (in_byte[7:4] == TAIL_NIBBLE);
	assign is_head = (in_byte == head_byte);

	// payload write port
	assign wr_en   = fire && (phase_q == PH_STORE);
	assign wr_bank = wb_q;
	assign wr_ofs  = cnt_q - CW'(1);
	assign wr_data = in_byte;

	// packet command on a good tail
	assign push          = fire && (phase_q == PH_TAIL) && tail_ok;
	assign push_cmd.tail = in_byte;
	assign push_cmd.bank = wb_q;

	// framing state and bank ownership
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			wb_q    <= 1'b0;
			busy_q  <= 2'b00;
		end else begin
			if (rel.valid) begin
				busy_q[rel.bank] <= 1'b0;
			end
			if (push) begin
				busy_q[wb_q] <= 1'b1;
				wb_q         <= !wb_q;
			end
			if (fire) begin
				unique case (phase_q)
					PH_STORE: begin
						if (cnt_q == CW'(PACKET_BYTES - 1)) begin
							phase_q <= PH_TAIL;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
					PH_TAIL: begin
						if (tail_ok) begin
							phase_q <= PH_IDLE;
							cnt_q   <= '0;
						end else if (is_head) begin
							phase_q <= PH_STORE;
							cnt_q   <= CW'(1);
						end else begin
							phase_q <= PH_IDLE;
							cnt_q   <= '0;
						end
					end
					default: begin
						if (is_head) begin
							phase_q <= PH_STORE;
							cnt_q   <= CW'(1);
						end else begin
							phase_q <= PH_IDLE;
							cnt_q   <= '0;
						end
					end
				endcase
			end
		end
	end

endmodule

### rtl/core/spd_queue.sv
// spd_queue: two-entry command queue between front and back
// depends on spd_pkg

module spd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spd_pkg::spd_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output spd_pkg::spd_cmd_t pop_cmd
);
	import spd_pkg::*;

	spd_cmd_t   ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_cmd   = ent_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/core/spd_back.sv
// spd_back: payload memory (two banks) and packet emitter
// depends on spd_pkg; takes commands from spd_queue, writes from spd_front

module spd_back #(
	parameter int PACKET_BYTES = spd_pkg::PACKET_BYTES_DEF,
	localparam int CW = $clog2(PACKET_BYTES),
	localparam int DEPTH = 2 * (PACKET_BYTES - 1),
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic              wr_bank,
	input  logic [CW-1:0]     wr_ofs,
	input  logic [7:0]        wr_data,
	input  logic              q_not_empty,
	input  spd_pkg::spd_cmd_t q_cmd,
	output logic              q_pop,
	output spd_pkg::spd_rel_t rel,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        data_byte,
	output logic              last_of_packet
);
	import spd_pkg::*;

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;

	logic          active_q;
	logic [CW-1:0] idx_q;
	logic          bank_q;
	logic [7:0]    tail_q;

	logic          out_valid_s2;
	logic          sel_tail_s2;
	logic          last_s2;
	logic [7:0]    tail_s2;
	logic [7:0]    rd_s2;

	logic          load;
	logic          issue;
	logic          final_beat;

	assign waddr = wr_bank ? (AW'(PACKET_BYTES - 1) + AW'(wr_ofs)) : AW'(wr_ofs);
	assign raddr = bank_q ? (AW'(PACKET_BYTES - 1) + AW'(idx_q - CW'(1)))
	                      : AW'(idx_q - CW'(1));

	assign load       = !out_valid_s2 || out_ready;
	assign issue      = active_q && load;
	assign final_beat = (idx_q == CW'(PACKET_BYTES - 1));
	assign q_pop      = !active_q && q_not_empty;

	assign rel.valid = issue && final_beat;
	assign rel.bank  = bank_q;

	// payload memory, registered read into the output stage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wr_data;
		end
		if (issue) begin
			rd_s2   <= mem[raddr];
			tail_s2 <= tail_q;
		end
	end

	// emit sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			idx_q        <= '0;
			bank_q       <= 1'b0;
			tail_q       <= '0;
			out_valid_s2 <= 1'b0;
			sel_tail_s2  <= 1'b0;
			last_s2      <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
				bank_q   <= q_cmd.bank;
				tail_q   <= q_cmd.tail;
			end
			if (issue) begin
				out_valid_s2 <= 1'b1;
				sel_tail_s2  <= (idx_q == '0);
				last_s2      <= final_beat;
				if (final_beat) begin
					active_q <= 1'b0;
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end else if (load) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_s2;
	assign data_byte      = sel_tail_s2 ? tail_s2 : rd_s2;
	assign last_of_packet = last_s2;

endmodule

### rtl/core/stream_packet_deframer_unit.sv
// stream_packet_deframer_unit: top level of the stream packet deframer
// depends on spd_pkg, spd_in_if, spd_out_if, spd_front, spd_queue, spd_back
//
//   channel     dir  payload                       beat when
//   in_stream   in   in_byte[7:0]                  valid && ready
//   out_stream  out  data_byte[7:0], last_of_packet valid && ready
//   apb         in   head_byte at paddr 0          psel && penable && pwrite
//
// input takes one byte a cycle; it stalls only while a payload byte would go
// into the bank whose packet is still queued or being emitted, or a tail meets a full queue
// output gives PACKET_BYTES beats per packet, one beat a cycle within a packet while
// the receiver is ready, from the single read port of the payload memory; an accepted
// tail goes through the queue, the emitter command registers and the output register
// before its first beat shows; arst_n clears framing, bank ownership, queue and output;
// the memory needs no clear; each side stalls on its own: the command queue and two banks sit between them

module stream_packet_deframer_unit #(
	parameter int PACKET_BYTES = spd_pkg::PACKET_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	spd_in_if.sink                      in_stream,
	spd_out_if.source                   out_stream,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [spd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import spd_pkg::*;

	localparam int CW = $clog2(PACKET_BYTES);

	logic [7:0]    head_q;
	logic          wr_en;
	logic          wr_bank;
	logic [CW-1:0] wr_ofs;
	logic [7:0]    wr_data;
	logic          push;
	spd_cmd_t      push_cmd;
	logic          q_full;
	logic          q_pop;
	logic          q_not_empty;
	spd_cmd_t      q_cmd;
	spd_rel_t      rel;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HEAD) ? {24'd0, head_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= HEAD_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_HEAD)) begin
			head_q <= pwdata[7:0];
		end
	end

	spd_front #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_byte(head_q),
		.in_valid (in_stream.valid),
		.in_ready (in_stream.ready),
		.in_byte  (in_stream.in_byte),
		.wr_en    (wr_en),
		.wr_bank  (wr_bank),
		.wr_ofs   (wr_ofs),
		.wr_data  (wr_data),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full),
		.rel      (rel)
	);

	spd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.pop_cmd  (q_cmd)
	);

	spd_back #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_bank       (wr_bank),
		.wr_ofs        (wr_ofs),
		.wr_data       (wr_data),
		.q_not_empty   (q_not_empty),
		.q_cmd         (q_cmd),
		.q_pop         (q_pop),
		.rel           (rel),
		.out_valid     (out_stream.valid),
		.out_ready     (out_stream.ready),
		.data_byte     (out_stream.data_byte),
		.last_of_packet(out_stream.last_of_packet)
	);

endmodule

### rtl/core/spd_checker.sv
// spd_checker: port-level checks on the deframer top level, with its bind
// depends on spd_pkg and stream_packet_deframer_unit

module spd_checker #(
	parameter int PACKET_BYTES = spd_pkg::PACKET_BYTES_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [7:0]                  data_byte,
	input logic                        last_of_packet,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [spd_pkg::PADDR_W-1:0] paddr,
	input logic [31:0]                 pwdata,
	input logic [31:0]                 prdata,
	input logic                        pready
);
	import spd_pkg::*;

	localparam int BW = $clog2(PACKET_BYTES);

	logic [BW-1:0] beat_q;
	logic          out_fire;

	assign out_fire = out_valid && out_ready;

	// beat position within the emitted packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= '0;
		end else if (out_fire) begin
			beat_q <= last_of_packet ? '0 : beat_q + BW'(1);
		end
	end

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(last_of_packet))
		else $error("output beat changed while stalled");

	// last flag exactly on the final beat of every packet
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> (last_of_packet == (beat_q == BW'(PACKET_BYTES - 1))))
		else $error("last_of_packet out of place");

	// written head byte reads back
	a_head_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[2] == REG_HEAD)
		|=> (paddr[2] != REG_HEAD) || (prdata[7:0] == $past(pwdata[7:0])))
		else $error("head byte readback mismatch");

	// unused register bits read zero, port never waits
	a_apb_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pready && (prdata[31:8] == 24'd0))
		else $error("configuration port misbehaves");

endmodule

bind stream_packet_deframer_unit spd_checker #(
	.PACKET_BYTES(PACKET_BYTES)
) u_spd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_stream.valid),
	.out_ready     (out_stream.ready),
	.data_byte     (out_stream.data_byte),
	.last_of_packet(out_stream.last_of_packet),
	.psel          (psel),
	.penable       (penable),
	.pwrite        (pwrite),
	.paddr         (paddr),
	.pwdata        (pwdata),
	.prdata        (prdata),
	.pready        (pready)
);

### sim/testbench.sv
`timescale 1ns / 100ps
// testbench: directed and random byte streams into stream_packet_deframer_unit,
// every packet beat checked against a deframer model held in this file
// depends on spd_pkg, spd_in_if, spd_out_if and the deframer rtl

module testbench;
	import spd_pkg::*;

	localparam int NBYTES = PACKET_BYTES_DEF;
	localparam int DRAIN_CYCLES = NBYTES + 16;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SPARE_REG = int'(REG_HEAD) + 1;
	localparam int PRINT_CAP = 50;

	typedef enum logic [1:0] {FR_IDLE, FR_STORE, FR_TAIL} frame_phase_t;
	typedef enum {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_mode_t;
	typedef enum {TAIL_GOOD, TAIL_BAD, TAIL_HEAD} tail_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_of_packet;
	} pkt_beat_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	spd_in_if  byte_in();
	spd_out_if pkt_out();

	stream_packet_deframer_unit #(.PACKET_BYTES(NBYTES)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_stream  (byte_in),
		.out_stream (pkt_out),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// deframer model state and its copy of the head register
	frame_phase_t frame_phase;
	int           frame_count;
	logic [7:0]   payload_copy [NBYTES-1];
	logic [7:0]   head_copy;

	pkt_beat_t  packet_beats_due [$];
	logic [7:0] raw_bytes_pending [$];
	int         bytes_queued;
	int         bytes_taken;
	int         mismatches;
	int         cycles;
	int         gap_left;
	int         stall_left;
	idle_mode_t in_idle;
	idle_mode_t out_idle;
	bit         hold_go;
	bit         out_parked;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
	endtask

	function automatic int draw_wait(input idle_mode_t mode);
		if (mode == IDLE_NONE)
			return 0;
		if (mode == IDLE_LIGHT)
			return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		return $urandom_range(0, 18);
	endfunction

	function automatic void open_on_head(input logic [7:0] b);
		if (b == head_copy) begin
			frame_phase = FR_STORE;
			frame_count = 1;
		end else begin
			frame_phase = FR_IDLE;
			frame_count = 0;
		end
	endfunction

	// one accepted byte through the framing model; a good tail queues the whole packet
	function automatic void deframe_byte(input logic [7:0] b);
		pkt_beat_t beat;
		case (frame_phase)
			FR_STORE: begin
				if (frame_count >= 1 && frame_count < NBYTES)
					payload_copy[frame_count - 1] = b;
				frame_count++;
				if (frame_count >= NBYTES)
					frame_phase = FR_TAIL;
			end
			FR_TAIL: begin
				if (b[7:4] == TAIL_NIBBLE) begin
					beat.data_byte = b;
					beat.last_of_packet = (NBYTES == 1);
					packet_beats_due.push_back(beat);
					for (int i = 0; i < NBYTES - 1; i++) begin
						beat.data_byte = payload_copy[i];
						beat.last_of_packet = (i == NBYTES - 2);
						packet_beats_due.push_back(beat);
					end
					frame_phase = FR_IDLE;
					frame_count = 0;
				end else begin
					open_on_head(b);
				end
			end
			default: open_on_head(b);
		endcase
	endfunction

	// setup then access cycle; reads compare the head register with the model copy
	task automatic apb_access(input bit wr, input int reg_idx, input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= PADDR_W'(4 * reg_idx);
		pwdata <= {24'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr && reg_idx == int'(REG_HEAD))
			head_copy = value;
		if (!wr && reg_idx == int'(REG_HEAD) && prdata[7:0] !== head_copy)
			report_mismatch("head_byte readback", prdata[7:0], head_copy);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic push_byte(input logic [7:0] b);
		raw_bytes_pending.push_back(b);
		bytes_queued++;
	endtask

	// payload after a head, then a tail byte of the given kind
	task automatic push_body(input tail_kind_t tail);
		logic [7:0] b;
		logic [3:0] nib;
		int         pick;
		for (int i = 0; i < NBYTES - 1; i++) begin
			pick = $urandom_range(0, 11);
			if (pick == 0)
				b = head_copy;
			else if (pick == 1)
				b = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
			else
				b = 8'($urandom);
			push_byte(b);
		end
		nib = 4'($urandom_range(0, 14));
		if (nib >= TAIL_NIBBLE)
			nib = nib + 4'd1;
		case (tail)
			TAIL_GOOD: push_byte({TAIL_NIBBLE, 4'($urandom)});
			TAIL_BAD:  push_byte({nib, 4'($urandom)});
			default:   push_byte(head_copy);
		endcase
	endtask

	// mostly whole packets with random content, some noise and broken framing
	task automatic queue_traffic(input int target, input bit clean);
		logic [7:0] b;
		int         stop_at;
		int         r;
		stop_at = bytes_queued + target;
		while (bytes_queued < stop_at) begin
			r = clean ? 0 : $urandom_range(0, 99);
			if (r < 62) begin
				push_byte(head_copy);
				push_body(TAIL_GOOD);
			end else if (r < 74) begin
				push_byte(head_copy);
				push_body(TAIL_BAD);
			end else if (r < 84) begin
				// a head in the tail slot restarts framing unless it also passes as a tail, the next body rides on it
				push_byte(head_copy);
				push_body(TAIL_HEAD);
				push_body(TAIL_GOOD);
			end else if (r < 93) begin
				repeat ($urandom_range(1, 4)) begin
					b = 8'($urandom);
					if (b == head_copy && $urandom_range(0, 3) != 0)
						b = b ^ 8'h01;
					push_byte(b);
				end
			end else begin
				push_byte(head_copy);
				repeat ($urandom_range(1, NBYTES - 2))
					push_byte(8'($urandom));
			end
		end
	endtask

	// wait for every byte to be taken and every packet beat to arrive
	task automatic settle();
		while (bytes_taken != bytes_queued)
			@(posedge clk);
		while (packet_beats_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// byte driver: one beat offered until taken, then the drawn gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in.valid <= 1'b0;
			byte_in.in_byte <= 8'h00;
			gap_left <= 0;
		end else begin
			if (byte_in.valid && byte_in.ready) begin
				deframe_byte(byte_in.in_byte);
				bytes_taken++;
			end
			if (!byte_in.valid || byte_in.ready) begin
				if (gap_left != 0) begin
					byte_in.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (raw_bytes_pending.size() != 0) begin
					byte_in.valid <= 1'b1;
					byte_in.in_byte <= raw_bytes_pending.pop_front();
					gap_left <= draw_wait(in_idle);
				end else begin
					byte_in.valid <= 1'b0;
				end
			end
		end
	end

	// receiver ready: a drawn stall after each beat, forced low while parked
	always @(posedge clk or negedge arst_n) begin : ready_drive
		int wait_now;
		if (!arst_n) begin
			pkt_out.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			wait_now = stall_left;
			if (pkt_out.valid && pkt_out.ready)
				wait_now = draw_wait(out_idle);
			pkt_out.ready <= !out_parked && wait_now == 0;
			stall_left <= (wait_now != 0) ? wait_now - 1 : 0;
		end
	end

	// long receiver hold so the block fills and stalls its input
	initial begin : long_hold
		while (!hold_go)
			@(posedge clk);
		out_parked <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		out_parked <= 1'b0;
	end

	// packet beat checker
	always @(posedge clk) begin : beat_check
		pkt_beat_t want;
		if (arst_n && pkt_out.valid && pkt_out.ready) begin
			if (packet_beats_due.size() == 0) begin
				report_mismatch("unexpected beat data_byte", pkt_out.data_byte, 0);
			end else begin
				want = packet_beats_due.pop_front();
				if (pkt_out.data_byte !== want.data_byte)
					report_mismatch("data_byte", pkt_out.data_byte, want.data_byte);
				if (pkt_out.last_of_packet !== want.last_of_packet)
					report_mismatch("last_of_packet", pkt_out.last_of_packet,
						want.last_of_packet);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_idle = IDLE_NONE;
		out_idle = IDLE_NONE;
		head_copy = HEAD_RESET;
		frame_phase = FR_IDLE;
		frame_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		apb_access(1'b0, REG_HEAD, 8'h00);

		// idle extremes, a head inside the payload, walking bits, top tail byte
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(head_copy);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(head_copy);
		for (int k = 0; k < 8; k++)
			push_byte(8'h01 << k);
		for (int k = 0; k < 8; k++)
			push_byte(~(8'h01 << k));
		push_byte({TAIL_NIBBLE, 4'hF});
		settle();

		in_idle = IDLE_LIGHT;
		out_idle = IDLE_LIGHT;
		queue_traffic(30, 1'b0);
		settle();

		// lowest head value, a write to an unmapped slot must leave it alone
		apb_access(1'b1, REG_HEAD, 8'h00);
		apb_access(1'b1, SPARE_REG, 8'h5A);
		apb_access(1'b0, REG_HEAD, 8'h00);
		in_idle = IDLE_FULL;
		out_idle = IDLE_FULL;
		queue_traffic(30, 1'b0);
		settle();

		// highest head value, back-to-back packets into a parked receiver
		apb_access(1'b1, REG_HEAD, 8'hFF);
		in_idle = IDLE_NONE;
		out_idle = IDLE_NONE;
		hold_go <= 1'b1;
		queue_traffic(60, 1'b1);
		settle();

		// head that also passes as a tail
		apb_access(1'b1, REG_HEAD, {TAIL_NIBBLE, 4'h3});
		in_idle = IDLE_FULL;
		out_idle = IDLE_NONE;
		queue_traffic(30, 1'b0);
		settle();

		apb_access(1'b1, REG_HEAD, 8'($urandom));
		apb_access(1'b0, REG_HEAD, 8'h00);
		in_idle = IDLE_NONE;
		out_idle = IDLE_FULL;
		queue_traffic(30, 1'b0);
		settle();

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### stream_packet_deframer_unit.f
rtl/core/spd_pkg.sv
rtl/core/spd_in_if.sv
rtl/core/spd_out_if.sv
rtl/core/spd_front.sv
rtl/core/spd_queue.sv
rtl/core/spd_back.sv
rtl/core/stream_packet_deframer_unit.sv
rtl/core/spd_checker.sv
sim/testbench.sv
